FILE: rtl/vn3_pkg.sv
// vn3_pkg: shared widths, types and stage records for the 3d vector normalizer
// used by every file under rtl; no dependencies
`default_nettype none
package vn3_pkg;
   localparam int FRAC_BITS = 16;
   localparam int IN_W   = 24;
   localparam int UNIT_W = 18;
   localparam int LEN_W  = 24;
   localparam int EPS_W  = 50;
   localparam int SQ_W   = 2 * IN_W;                // sum of three squares needs 48 bits
   localparam int MAG_W  = IN_W;                    // |c| up to 2^23
   localparam int NUM_W  = MAG_W + FRAC_BITS;       // dividend width
   localparam int RT_BITS = (SQ_W + 1) / 2;         // root bits, 24
   localparam int QB     = FRAC_BITS + 1;           // quotient bits, magnitude <= 1.0
   localparam int RREM_W = RT_BITS + 2;
   localparam int DREM_W = LEN_W + 1;
   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(430);
   localparam logic [UNIT_W-1:0] ONE_UNIT = UNIT_W'(1) << FRAC_BITS;
   localparam logic [LEN_W-1:0]  ONE_LEN  = LEN_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic               valid;
      logic               degen;
      logic [SQ_W-1:0]    rad;    // remaining radicand bits, shifted left
      logic [RREM_W-1:0]  rrem;
      logic [RT_BITS-1:0] root;
      logic [2:0]         neg;
      logic [NUM_W-1:0]   mag_x;
      logic [NUM_W-1:0]   mag_y;
      logic [NUM_W-1:0]   mag_z;
   } sqrt_stage_type;

   typedef struct packed {
      logic              valid;
      logic              degen;
      logic [LEN_W-1:0]  len;
      logic [2:0]        neg;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [NUM_W-1:0]  num_z;
      logic [DREM_W-1:0] rem_x;
      logic [DREM_W-1:0] rem_y;
      logic [DREM_W-1:0] rem_z;
      logic [QB-1:0]     q_x;
      logic [QB-1:0]     q_y;
      logic [QB-1:0]     q_z;
   } div_stage_type;
endpackage
`default_nettype wire

FILE: rtl/vn3_sqrt_cell.sv
// vn3_sqrt_cell: one restoring square-root digit per cell, registered
// depends on vn3_pkg
`default_nettype none
module vn3_sqrt_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  vn3_pkg::sqrt_stage_type      stage_in,
   output vn3_pkg::sqrt_stage_type      stage_out
);
   vn3_pkg::sqrt_stage_type stage_ff, stage_ff_in;
   logic [vn3_pkg::RREM_W-1:0] trial, cand;

   always_comb begin
      stage_ff_in = stage_in;
      cand  = {stage_in.rrem[vn3_pkg::RREM_W-3:0], stage_in.rad[vn3_pkg::SQ_W-1 -: 2]};
      trial = {stage_in.root, 2'b01};
      stage_ff_in.rad = stage_in.rad << 2;
      if (cand >= trial) begin
         stage_ff_in.rrem = cand - trial;
         stage_ff_in.root = {stage_in.root[vn3_pkg::RT_BITS-2:0], 1'b1};
      end else begin
         stage_ff_in.rrem = cand;
         stage_ff_in.root = {stage_in.root[vn3_pkg::RT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_ff_in;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

FILE: rtl/vn3_div_cell.sv
// vn3_div_cell: one restoring division bit for all three components
// depends on vn3_pkg
`default_nettype none
module vn3_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  vn3_pkg::div_stage_type      stage_in,
   output vn3_pkg::div_stage_type      stage_out
);
   vn3_pkg::div_stage_type stage_ff, stage_ff_in;

   function automatic logic [vn3_pkg::DREM_W:0] div_bit(
      input logic [vn3_pkg::DREM_W-1:0] rem, input logic nb,
      input logic [vn3_pkg::LEN_W-1:0] len);
      logic [vn3_pkg::DREM_W-1:0] c;
      c = {rem[vn3_pkg::DREM_W-2:0], nb};
      if (c >= {1'b0, len}) div_bit = {1'b1, c - {1'b0, len}};
      else div_bit = {1'b0, c};
   endfunction

   logic [vn3_pkg::DREM_W:0] rx, ry, rz;

   always_comb begin
      stage_ff_in = stage_in;
      rx = div_bit(stage_in.rem_x, stage_in.num_x[vn3_pkg::NUM_W-1], stage_in.len);
      ry = div_bit(stage_in.rem_y, stage_in.num_y[vn3_pkg::NUM_W-1], stage_in.len);
      rz = div_bit(stage_in.rem_z, stage_in.num_z[vn3_pkg::NUM_W-1], stage_in.len);
      stage_ff_in.num_x = stage_in.num_x << 1;
      stage_ff_in.num_y = stage_in.num_y << 1;
      stage_ff_in.num_z = stage_in.num_z << 1;
      stage_ff_in.rem_x = rx[vn3_pkg::DREM_W-1:0];
      stage_ff_in.rem_y = ry[vn3_pkg::DREM_W-1:0];
      stage_ff_in.rem_z = rz[vn3_pkg::DREM_W-1:0];
      stage_ff_in.q_x = {stage_in.q_x[vn3_pkg::QB-2:0], rx[vn3_pkg::DREM_W]};
      stage_ff_in.q_y = {stage_in.q_y[vn3_pkg::QB-2:0], ry[vn3_pkg::DREM_W]};
      stage_ff_in.q_z = {stage_in.q_z[vn3_pkg::QB-2:0], rz[vn3_pkg::DREM_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_ff_in;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

FILE: rtl/vector_normalize_3d_top.sv
// vector_normalize_3d_top: 3d vector normalizer, square-root and divider cell chains
// depends on vn3_pkg, vn3_sqrt_cell, vn3_div_cell
// pipeline: 1 square stage, 24 root cells, 1 setup register, 40 divider cells and 1 output register
// throughput: one request per cycle; the whole chain advances when the output is free
//   or about to be taken, so a full pipe stalls only while rsp_ready is low
// reset: synchronous, clears every stage valid bit and loads epsilon_sq with 430
`default_nettype none
module vector_normalize_3d_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [23:0] req_vec_x,
   input  wire logic signed [23:0] req_vec_y,
   input  wire logic signed [23:0] req_vec_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [17:0] rsp_unit_x,
   output logic signed [17:0] rsp_unit_y,
   output logic signed [17:0] rsp_unit_z,
   output logic [23:0]      rsp_length,
   output logic             rsp_degenerate,
   input  wire logic        csr_we,
   input  wire logic [49:0] csr_wdata
);
   localparam int DIV_CELLS = vn3_pkg::NUM_W;

   logic [vn3_pkg::EPS_W-1:0] eps_ff;
   logic advance;   // global pipeline enable

   always_ff @(posedge clock) begin
      if (reset) eps_ff <= vn3_pkg::EPS_RESET;
      else if (csr_we) eps_ff <= csr_wdata;
   end

   // output register free or being drained: everything moves
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 0: squares and magnitudes
   logic [vn3_pkg::MAG_W-1:0] ax, ay, az;
   logic [vn3_pkg::SQ_W-1:0]  sq;
   vn3_pkg::sqrt_stage_type s0_ff, s0_in;
   assign ax = req_vec_x[23] ? vn3_pkg::MAG_W'(-req_vec_x) : vn3_pkg::MAG_W'(req_vec_x);
   assign ay = req_vec_y[23] ? vn3_pkg::MAG_W'(-req_vec_y) : vn3_pkg::MAG_W'(req_vec_y);
   assign az = req_vec_z[23] ? vn3_pkg::MAG_W'(-req_vec_z) : vn3_pkg::MAG_W'(req_vec_z);
   assign sq = vn3_pkg::SQ_W'(ax * ax) + vn3_pkg::SQ_W'(ay * ay) + vn3_pkg::SQ_W'(az * az);

   always_comb begin
      s0_in.valid = req_valid;
      s0_in.degen = {2'b00, sq} <= eps_ff;
      s0_in.rad   = sq;
      s0_in.rrem  = '0;
      s0_in.root  = '0;
      s0_in.neg   = {req_vec_z[23], req_vec_y[23], req_vec_x[23]};
      s0_in.mag_x = vn3_pkg::NUM_W'(ax);
      s0_in.mag_y = vn3_pkg::NUM_W'(ay);
      s0_in.mag_z = vn3_pkg::NUM_W'(az);
   end

   always_ff @(posedge clock) begin
      if (reset) s0_ff.valid <= 1'b0;
      else if (advance) s0_ff <= s0_in;
   end

   // square-root chain, two radicand bits per cell from the top
   vn3_pkg::sqrt_stage_type sq_chain [vn3_pkg::RT_BITS+1];
   assign sq_chain[0] = s0_ff;
   for (genvar i = 0; i < vn3_pkg::RT_BITS; i++) begin : g_sqrt
      vn3_sqrt_cell u_cell (.clock, .reset, .enable(advance),
                            .stage_in(sq_chain[i]), .stage_out(sq_chain[i+1]));
   end

   // divider setup: numerators are magnitude << FRAC_BITS
   vn3_pkg::sqrt_stage_type sr;
   vn3_pkg::div_stage_type dv_ff, dv_in;
   logic [vn3_pkg::LEN_W-1:0] len_c;
   assign sr = sq_chain[vn3_pkg::RT_BITS];
   assign len_c = sr.degen ? vn3_pkg::ONE_LEN : sr.root;

   always_comb begin
      dv_in.valid = sr.valid;
      dv_in.degen = sr.degen;
      dv_in.len   = len_c;
      dv_in.neg   = sr.neg;
      dv_in.num_x = sr.mag_x << vn3_pkg::FRAC_BITS;
      dv_in.num_y = sr.mag_y << vn3_pkg::FRAC_BITS;
      dv_in.num_z = sr.mag_z << vn3_pkg::FRAC_BITS;
      dv_in.rem_x = '0;
      dv_in.rem_y = '0;
      dv_in.rem_z = '0;
      dv_in.q_x = '0;
      dv_in.q_y = '0;
      dv_in.q_z = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff.valid <= 1'b0;
      else if (advance) dv_ff <= dv_in;
   end

   // long-division chain, one quotient bit per cell; quotient keeps the low QB bits
   vn3_pkg::div_stage_type dv_chain [DIV_CELLS+1];
   assign dv_chain[0] = dv_ff;
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      vn3_div_cell u_cell (.clock, .reset, .enable(advance),
                           .stage_in(dv_chain[i]), .stage_out(dv_chain[i+1]));
   end

   // output register with sign restore and fallback vector
   vn3_pkg::div_stage_type df;
   logic [vn3_pkg::UNIT_W-1:0] ux, uy, uz;
   assign df = dv_chain[DIV_CELLS];
   assign ux = df.neg[0] ? -vn3_pkg::UNIT_W'(df.q_x) : vn3_pkg::UNIT_W'(df.q_x);
   assign uy = df.neg[1] ? -vn3_pkg::UNIT_W'(df.q_y) : vn3_pkg::UNIT_W'(df.q_y);
   assign uz = df.neg[2] ? -vn3_pkg::UNIT_W'(df.q_z) : vn3_pkg::UNIT_W'(df.q_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid      <= df.valid;
         rsp_unit_x     <= df.degen ? vn3_pkg::ONE_UNIT : ux;
         rsp_unit_y     <= df.degen ? '0 : uy;
         rsp_unit_z     <= df.degen ? '0 : uz;
         rsp_length     <= df.len;
         rsp_degenerate <= df.degen;
      end
   end

   // a stalled response must hold
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_x) && $stable(rsp_length))
      else $error("response changed while stalled");
   // degenerate results carry the fallback vector
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_unit_x == vn3_pkg::ONE_UNIT && rsp_unit_y == '0
         && rsp_length == vn3_pkg::ONE_LEN)
      else $error("bad fallback result");
   // nondegenerate length is never zero
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_length != '0)
      else $error("zero length on valid vector");
endmodule
`default_nettype wire
